/* rtl/core/jstok_pkg.sv */
// jstok_pkg: types, constants and byte classifiers for the script string tokenizer
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package jstok_pkg;

   localparam int STRING_DEPTH = 64;
   localparam int ADDR_W = (STRING_DEPTH > 1) ? $clog2(STRING_DEPTH) : 1;
   localparam int CNT_W = $clog2(STRING_DEPTH + 1);

   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_BTICK = 8'h60;
   localparam logic [7:0] CH_SLASH = 8'h2f;
   localparam logic [7:0] CH_STAR = 8'h2a;
   localparam logic [7:0] CH_BSLASH = 8'h5c;
   localparam logic [7:0] CH_LF = 8'h0a;
   localparam logic [7:0] CH_CR = 8'h0d;
   localparam logic [7:0] CH_TAB = 8'h09;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_COMMA = 8'h2c;
   localparam logic [7:0] CH_SEMI = 8'h3b;
   localparam logic [7:0] CH_COLON = 8'h3a;

   localparam logic [1:0] QUOTE_NONE = 2'd0;
   localparam logic [1:0] QUOTE_SINGLE = 2'd1;
   localparam logic [1:0] QUOTE_DOUBLE = 2'd2;
   localparam logic [1:0] QUOTE_BTICK = 2'd3;

   typedef enum logic [2:0] {
      MODE_NORMAL = 3'd0,
      MODE_SLASH = 3'd1,
      MODE_LINE = 3'd2,
      MODE_BLOCK = 3'd3,
      MODE_BLOCK_STAR = 3'd4,
      MODE_STRING = 3'd5,
      MODE_ESCAPE = 3'd6
   } scan_mode_type;

   typedef enum logic [1:0] {
      DR_IDLE = 2'd0,
      DR_RUN = 2'd1,
      DR_FLUSH = 2'd2
   } drain_state_type;

   // closing quote hands the buffered string over to the drain
   typedef struct packed {
      logic start;
      logic [CNT_W-1:0] len;
      logic ovf;
   } drain_start_type;

   function automatic logic [1:0] quote_code(input logic [7:0] c);
      logic [1:0] q;
      case (c)
         CH_SQUOTE: q = QUOTE_SINGLE;
         CH_DQUOTE: q = QUOTE_DOUBLE;
         CH_BTICK: q = QUOTE_BTICK;
         default: q = QUOTE_NONE;
      endcase
      return q;
   endfunction

   function automatic logic is_delim(input logic [7:0] c);
      return c inside {CH_SPACE, CH_TAB, CH_LF, CH_CR, CH_COMMA, CH_SEMI, CH_COLON};
   endfunction

endpackage

/* rtl/core/jstok_buffer.sv */
// jstok_buffer: string buffer, one write port and one registered read port
// depends on jstok_pkg
`timescale 1ns / 1ps

module jstok_buffer
   import jstok_pkg::*;
(
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_data
);

   logic [7:0] mem [STRING_DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/jstok_scanner.sv */
// jstok_scanner: comment/string mode machine, fills the string buffer
// depends on jstok_pkg
`timescale 1ns / 1ps

module jstok_scanner
   import jstok_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [7:0]        in_byte,
   input  logic              end_of_input,
   output logic              wr_en,
   output logic [ADDR_W-1:0] wr_addr,
   output logic [7:0]        wr_data,
   output drain_start_type   start
);

   scan_mode_type mode_ff, mode_in;
   logic [1:0] quote_ff, quote_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic ovf_ff, ovf_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_NORMAL;
         quote_ff <= QUOTE_NONE;
         fill_ff <= '0;
         ovf_ff <= 1'b0;
      end else begin
         mode_ff <= mode_in;
         quote_ff <= quote_in;
         fill_ff <= fill_in;
         ovf_ff <= ovf_in;
      end
   end

   always_comb begin
      logic push;
      logic [1:0] q;
      push = 1'b0;
      q = quote_code(in_byte);
      mode_in = mode_ff;
      quote_in = quote_ff;
      fill_in = fill_ff;
      ovf_in = ovf_ff;
      start.start = 1'b0;
      start.len = fill_ff;
      start.ovf = ovf_ff;
      if (accept) begin
         case (mode_ff)
            MODE_LINE: begin
               if (in_byte == CH_LF) mode_in = MODE_NORMAL;
            end
            MODE_BLOCK: begin
               if (in_byte == CH_STAR) mode_in = MODE_BLOCK_STAR;
            end
            MODE_BLOCK_STAR: begin
               if (in_byte == CH_SLASH) mode_in = MODE_NORMAL;
               else if (in_byte != CH_STAR) mode_in = MODE_BLOCK;
            end
            MODE_STRING: begin
               if (in_byte == CH_BSLASH) begin
                  push = 1'b1;
                  mode_in = MODE_ESCAPE;
               end else if (q != QUOTE_NONE && q == quote_ff) begin
                  start.start = 1'b1;
                  mode_in = MODE_NORMAL;
                  quote_in = QUOTE_NONE;
                  fill_in = '0;
                  ovf_in = 1'b0;
               end else begin
                  push = 1'b1;
               end
            end
            MODE_ESCAPE: begin
               push = 1'b1;
               mode_in = MODE_STRING;
            end
            default: begin
               // normal, pending slash and unused codes
               if (mode_ff == MODE_SLASH && in_byte == CH_SLASH) begin
                  mode_in = MODE_LINE;
               end else if (mode_ff == MODE_SLASH && in_byte == CH_STAR) begin
                  mode_in = MODE_BLOCK;
               end else if (q != QUOTE_NONE) begin
                  mode_in = MODE_STRING;
                  quote_in = q;
                  fill_in = '0;
                  ovf_in = 1'b0;
               end else if (in_byte == CH_SLASH) begin
                  mode_in = MODE_SLASH;
               end else begin
                  mode_in = MODE_NORMAL;
               end
            end
         endcase
         if (push) begin
            if (fill_ff < CNT_W'(STRING_DEPTH)) fill_in = fill_ff + CNT_W'(1);
            else ovf_in = 1'b1;
         end
         if (end_of_input) begin
            mode_in = MODE_NORMAL;
            quote_in = QUOTE_NONE;
            fill_in = '0;
            ovf_in = 1'b0;
         end
      end
      wr_en = push && (fill_ff < CNT_W'(STRING_DEPTH));
   end

   assign wr_addr = fill_ff[ADDR_W-1:0];
   assign wr_data = in_byte;

endmodule

/* rtl/core/jstok_drain.sv */
// jstok_drain: reads the buffered string back, splits it into tokens, drives the response register
// depends on jstok_pkg
`timescale 1ns / 1ps

module jstok_drain
   import jstok_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  drain_start_type   start,
   output logic [ADDR_W-1:0] rd_addr,
   input  logic [7:0]        rd_data,
   output logic              idle,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [7:0]        out_char,
   output logic              out_end,
   output logic              out_trunc,
   output logic              out_last
);

   drain_state_type state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] len_ff, len_in;
   logic ovf_ff, ovf_in;
   logic dvalid_ff, dvalid_in;
   logic hold_valid_ff, hold_valid_in;
   logic [7:0] hold_char_ff, hold_char_in;
   logic hold_end_ff, hold_end_in;
   logic out_valid_ff, out_valid_in;
   logic [7:0] out_char_ff, out_char_in;
   logic out_end_ff, out_end_in;
   logic out_trunc_ff, out_trunc_in;
   logic out_last_ff, out_last_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DR_IDLE;
         dvalid_ff <= 1'b0;
         hold_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         dvalid_ff <= dvalid_in;
         hold_valid_ff <= hold_valid_in;
         out_valid_ff <= out_valid_in;
      end
      cnt_ff <= cnt_in;
      len_ff <= len_in;
      ovf_ff <= ovf_in;
      hold_char_ff <= hold_char_in;
      hold_end_ff <= hold_end_in;
      out_char_ff <= out_char_in;
      out_end_ff <= out_end_in;
      out_trunc_ff <= out_trunc_in;
      out_last_ff <= out_last_in;
   end

   always_comb begin
      logic can_push;
      logic push;
      logic is_d;
      logic need_push;
      logic [CNT_W-1:0] nxt;
      can_push = !out_valid_ff || out_ready;
      push = 1'b0;
      is_d = is_delim(rd_data);
      need_push = 1'b0;
      nxt = cnt_ff + CNT_W'(1);
      state_in = state_ff;
      cnt_in = cnt_ff;
      len_in = len_ff;
      ovf_in = ovf_ff;
      dvalid_in = dvalid_ff;
      hold_valid_in = hold_valid_ff;
      hold_char_in = hold_char_ff;
      hold_end_in = hold_end_ff;
      out_char_in = out_char_ff;
      out_end_in = out_end_ff;
      out_trunc_in = out_trunc_ff;
      out_last_in = out_last_ff;
      rd_addr = cnt_ff[ADDR_W-1:0];
      case (state_ff)
         DR_IDLE: begin
            if (start.start && start.len != '0) begin
               state_in = DR_RUN;
               cnt_in = '0;
               len_in = start.len;
               ovf_in = start.ovf;
               dvalid_in = 1'b0;
               hold_valid_in = 1'b0;
            end
         end
         DR_RUN: begin
            if (!dvalid_ff) begin
               dvalid_in = 1'b1;
            end else begin
               need_push = !is_d && hold_valid_ff;
               if (!need_push || can_push) begin
                  if (is_d) begin
                     hold_end_in = 1'b1;
                  end else begin
                     if (hold_valid_ff) begin
                        push = 1'b1;
                        out_char_in = hold_char_ff;
                        out_end_in = hold_end_ff;
                        out_trunc_in = ovf_ff;
                        out_last_in = 1'b0;
                     end
                     hold_valid_in = 1'b1;
                     hold_char_in = rd_data;
                     hold_end_in = 1'b0;
                  end
                  cnt_in = nxt;
                  rd_addr = nxt[ADDR_W-1:0];
                  if (nxt >= len_ff) begin
                     state_in = DR_FLUSH;
                     dvalid_in = 1'b0;
                  end
               end
            end
         end
         DR_FLUSH: begin
            if (!hold_valid_ff) begin
               state_in = DR_IDLE;
            end else if (can_push) begin
               push = 1'b1;
               out_char_in = hold_char_ff;
               out_end_in = 1'b1;
               out_trunc_in = ovf_ff;
               out_last_in = 1'b1;
               hold_valid_in = 1'b0;
               state_in = DR_IDLE;
            end
         end
         default: begin
            state_in = DR_IDLE;
         end
      endcase
      if (push) out_valid_in = 1'b1;
      else if (out_ready) out_valid_in = 1'b0;
      else out_valid_in = out_valid_ff;
   end

   assign idle = (state_ff == DR_IDLE);
   assign out_valid = out_valid_ff;
   assign out_char = out_char_ff;
   assign out_end = out_end_ff;
   assign out_trunc = out_trunc_ff;
   assign out_last = out_last_ff;

endmodule

/* rtl/core/js_string_literal_tokenizer.sv */
// js_string_literal_tokenizer: top level of the script string tokenizer
// depends on jstok_pkg, jstok_scanner, jstok_buffer, jstok_drain
//
// usage:
//   req channel carries the script text, one byte per request (tdata = in_byte,
//   tlast = end_of_input). rsp channel carries token bytes (tdata = token_char,
//   tuser = token_end, truncated from bit 0 up; tlast = last byte of a run).
//   while the drain is idle a request is taken every cycle; comments are skipped
//   and string bytes go into a 64-entry buffer memory.
//   a closing quote of a non-empty string starts the drain: req_tready drops and
//   the buffer is read back one byte per cycle while the receiver does not stall
//   (a registered read, a wait for the first read data and a flush step), so a
//   string of n buffered bytes holds off the next request until all n bytes are
//   read and flushed, plus any receiver stall. token bytes follow at most one
//   per cycle.
//   when the receiver stalls, the drain waits on the response register and
//   the buffer read is held, nothing is lost.
//   reset clears the scan mode, fill count and all pending output; the buffer
//   memory itself is not cleared. a request with tlast returns all scan state
//   to its reset value after the byte is handled.
`timescale 1ns / 1ps

module js_string_literal_tokenizer
   import jstok_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,  // [7:0] in_byte
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,  // [7:0] token_char
   output logic [1:0] rsp_tuser,  // [0] token_end, [1] truncated
   output logic       rsp_tlast
);

   logic accept;
   logic wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [7:0] wr_data;
   logic [ADDR_W-1:0] rd_addr;
   logic [7:0] rd_data;
   logic idle;
   drain_start_type start;
   logic out_end;
   logic out_trunc;

   assign req_tready = idle;
   assign accept = req_tvalid && req_tready;

   jstok_scanner u_scanner (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .in_byte      (req_tdata),
      .end_of_input (req_tlast),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data),
      .start        (start)
   );

   jstok_buffer u_buffer (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   jstok_drain u_drain (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .idle      (idle),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_char  (rsp_tdata),
      .out_end   (out_end),
      .out_trunc (out_trunc),
      .out_last  (rsp_tlast)
   );

   assign rsp_tuser = {out_trunc, out_end};

endmodule

/* tb/sv/js_string_literal_tokenizer_checker.sv */
// js_string_literal_tokenizer_checker: watches both streams of the tokenizer, predicts token bytes
// from the accepted script text and compares every response field; depends on jstok_pkg
`timescale 1ns / 1ps

module js_string_literal_tokenizer_checker
   import jstok_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tready,
   input  logic [7:0] req_tdata,  // [7:0] in_byte
   input  logic       req_tlast,
   input  logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  logic [7:0] rsp_tdata,  // [7:0] token_char
   input  logic [1:0] rsp_tuser,  // [0] token_end, [1] truncated
   input  logic       rsp_tlast,
   output int         fail_count,
   output int         pending_count,
   output int         token_count,
   output int         truncated_count
);

   typedef struct packed {
      logic [7:0] token_char;
      logic token_end;
      logic truncated;
      logic run_last;
   } token_byte_type;

   token_byte_type expected_tokens[$];
   scan_mode_type scan_mode;
   logic [1:0] open_quote;
   logic [7:0] literal_bytes[STRING_DEPTH];
   int literal_len;
   logic literal_cut;

   function automatic logic [1:0] quote_kind(input logic [7:0] c);
      if (c == CH_SQUOTE) return QUOTE_SINGLE;
      if (c == CH_DQUOTE) return QUOTE_DOUBLE;
      if (c == CH_BTICK) return QUOTE_BTICK;
      return QUOTE_NONE;
   endfunction

   function automatic logic separates(input logic [7:0] c);
      case (c)
         CH_SPACE, CH_TAB, CH_LF, CH_CR, CH_COMMA, CH_SEMI, CH_COLON: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   task automatic clear_scan();
      scan_mode = MODE_NORMAL;
      open_quote = QUOTE_NONE;
      literal_len = 0;
      literal_cut = 1'b0;
   endtask

   // byte seen outside strings and comments
   task automatic code_byte(input logic [7:0] c);
      logic [1:0] q;
      q = quote_kind(c);
      if (q != QUOTE_NONE) begin
         scan_mode = MODE_STRING;
         open_quote = q;
         literal_len = 0;
         literal_cut = 1'b0;
      end else if (c == CH_SLASH) begin
         scan_mode = MODE_SLASH;
      end else begin
         scan_mode = MODE_NORMAL;
      end
   endtask

   task automatic keep_byte(input logic [7:0] c);
      if (literal_len < STRING_DEPTH) begin
         literal_bytes[literal_len] = c;
         literal_len++;
      end else begin
         literal_cut = 1'b1;
      end
   endtask

   // one token byte per non-separator, last one of the run carries run_last
   task automatic split_literal();
      token_byte_type held;
      logic have_held;
      held = '0;
      have_held = 1'b0;
      for (int i = 0; i < literal_len; i++) begin
         if (!separates(literal_bytes[i])) begin
            if (have_held) expected_tokens.push_back(held);
            held.token_char = literal_bytes[i];
            held.token_end = (i + 1 >= literal_len) || separates(literal_bytes[i + 1]);
            held.truncated = literal_cut;
            held.run_last = 1'b0;
            have_held = 1'b1;
         end
      end
      if (have_held) begin
         held.run_last = 1'b1;
         expected_tokens.push_back(held);
      end
   endtask

   task automatic take_byte(input logic [7:0] c, input logic eoi);
      case (scan_mode)
         MODE_SLASH: begin
            if (c == CH_SLASH) scan_mode = MODE_LINE;
            else if (c == CH_STAR) scan_mode = MODE_BLOCK;
            else code_byte(c);
         end
         MODE_LINE: begin
            if (c == CH_LF) scan_mode = MODE_NORMAL;
         end
         MODE_BLOCK: begin
            if (c == CH_STAR) scan_mode = MODE_BLOCK_STAR;
         end
         MODE_BLOCK_STAR: begin
            if (c == CH_SLASH) scan_mode = MODE_NORMAL;
            else if (c != CH_STAR) scan_mode = MODE_BLOCK;
         end
         MODE_STRING: begin
            if (c == CH_BSLASH) begin
               keep_byte(c);
               scan_mode = MODE_ESCAPE;
            end else if (quote_kind(c) != QUOTE_NONE && quote_kind(c) == open_quote) begin
               split_literal();
               clear_scan();
            end else begin
               keep_byte(c);
            end
         end
         MODE_ESCAPE: begin
            keep_byte(c);
            scan_mode = MODE_STRING;
         end
         default: code_byte(c);
      endcase
      if (eoi) clear_scan();
   endtask

   task automatic compare_field(input string field, input logic [7:0] want,
                                input logic [7:0] got);
      if (got !== want) begin
         fail_count++;
         $error("%s: expected %0h, got %0h", field, want, got);
      end
   endtask

   always @(posedge clock) begin
      token_byte_type want;
      if (reset) begin
         clear_scan();
         expected_tokens.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            token_count++;
            if (rsp_tuser[1]) truncated_count++;
            if (expected_tokens.size() == 0) begin
               fail_count++;
               $error("token byte %0h arrived with no token byte expected", rsp_tdata);
            end else begin
               want = expected_tokens.pop_front();
               compare_field("token_char", want.token_char, rsp_tdata);
               compare_field("token_end", 8'(want.token_end), 8'(rsp_tuser[0]));
               compare_field("truncated", 8'(want.truncated), 8'(rsp_tuser[1]));
               compare_field("run_last", 8'(want.run_last), 8'(rsp_tlast));
            end
         end
         if (req_tvalid && req_tready) take_byte(req_tdata, req_tlast);
      end
      pending_count <= expected_tokens.size();
   end

endmodule

/* tb/sv/js_string_literal_tokenizer_tb.sv */
// js_string_literal_tokenizer_tb: drives script text into the tokenizer with bursty requests
// and a stalling receiver, and gives the verdict; depends on jstok_pkg, the block and its checker
`timescale 1ns / 1ps

module js_string_literal_tokenizer_tb;
   import jstok_pkg::*;

   localparam int TEXT_TARGET = 420;
   localparam int CYCLE_LIMIT = 200000;
   localparam int LONG_HOLD = 300;
   localparam int SETTLE_CYCLES = 20;

   typedef struct packed {
      logic [7:0] text;
      logic last;
   } text_request_type;

   typedef enum logic [1:0] {
      RX_STEADY = 2'd0,
      RX_COIN = 2'd1,
      RX_SPARSE = 2'd2,
      RX_ALTERNATE = 2'd3
   } ready_style_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [7:0] req_tdata = 8'h00;
   logic req_tlast = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic [1:0] rsp_tuser;
   logic rsp_tlast;

   int fail_count;
   int pending_count;
   int token_count;
   int truncated_count;

   text_request_type script_text[$];
   int directed_len;
   int eoi_count = 0;
   int burst_left = 0;
   int cycle_count = 0;
   logic hold_go = 1'b0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   js_string_literal_tokenizer i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

   js_string_literal_tokenizer_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tlast      (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .rsp_tlast      (rsp_tlast),
      .fail_count     (fail_count),
      .pending_count  (pending_count),
      .token_count    (token_count),
      .truncated_count(truncated_count)
   );

   function automatic logic [7:0] any_letter();
      return 8'h61 + 8'($urandom_range(0, 25));
   endfunction

   function automatic logic [7:0] any_delim();
      case ($urandom_range(0, 6))
         0: return CH_SPACE;
         1: return CH_TAB;
         2: return CH_LF;
         3: return CH_CR;
         4: return CH_COMMA;
         5: return CH_SEMI;
         default: return CH_COLON;
      endcase
   endfunction

   function automatic logic [7:0] any_quote();
      case ($urandom_range(0, 2))
         0: return CH_SQUOTE;
         1: return CH_DQUOTE;
         default: return CH_BTICK;
      endcase
   endfunction

   task automatic add_text(input logic [7:0] b);
      script_text.push_back({b, 1'b0});
   endtask

   task automatic add_end(input logic [7:0] b);
      script_text.push_back({b, 1'b1});
   endtask

   // quoted string with separators, foreign quotes, escapes and raw bytes; some overflow
   task automatic add_string();
      logic [7:0] close_q;
      logic [7:0] c;
      int len;
      int r;
      close_q = any_quote();
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(56, 76) : $urandom_range(0, 14);
      add_text(close_q);
      for (int n = 0; n < len; n++) begin
         r = $urandom_range(0, 19);
         if (r < 8) begin
            add_text(any_letter());
         end else if (r < 12) begin
            add_text(any_delim());
         end else if (r < 14) begin
            c = any_quote();
            add_text(c == close_q ? any_letter() : c);
         end else if (r < 16) begin
            add_text(CH_BSLASH);
            add_text($urandom_range(0, 1) ? close_q : 8'($urandom_range(0, 255)));
         end else begin
            c = 8'($urandom_range(0, 255));
            if (c == close_q) c = any_letter();
            add_text(c);
            if (c == CH_BSLASH) add_text(any_letter());
         end
      end
      if ($urandom_range(0, 9) == 0) add_end(close_q);
      else add_text(close_q);
   endtask

   task automatic add_line_comment();
      logic [7:0] c;
      add_text(CH_SLASH);
      add_text(CH_SLASH);
      repeat ($urandom_range(0, 12)) begin
         c = 8'($urandom_range(0, 255));
         add_text(c == CH_LF ? any_letter() : c);
      end
      add_text(CH_LF);
   endtask

   // no slash inside the body, so only the closing star run ends it
   task automatic add_block_comment();
      logic [7:0] c;
      add_text(CH_SLASH);
      add_text(CH_STAR);
      repeat ($urandom_range(0, 12)) begin
         c = 8'($urandom_range(0, 255));
         add_text(c == CH_SLASH ? CH_STAR : c);
      end
      repeat ($urandom_range(1, 3)) add_text(CH_STAR);
      add_text(CH_SLASH);
   endtask

   task automatic add_code();
      int r;
      repeat ($urandom_range(1, 10)) begin
         r = $urandom_range(0, 9);
         if (r == 0) begin
            add_text(CH_SLASH);
            add_text(any_letter());
         end else if (r == 1) begin
            add_text(CH_SPACE);
         end else if (r == 2) begin
            add_text(CH_LF);
         end else begin
            add_text(any_letter());
         end
      end
      if ($urandom_range(0, 9) == 0) add_end(any_letter());
   endtask

   task automatic add_noise();
      repeat ($urandom_range(1, 8))
         script_text.push_back({8'($urandom_range(0, 255)), 1'($urandom_range(0, 19) == 0)});
   endtask

   // input ends inside a string, an escape, a comment or after a lone slash
   task automatic add_cut_off();
      case ($urandom_range(0, 3))
         0: begin
            add_text(any_quote());
            repeat ($urandom_range(0, 5)) add_text(any_letter());
            add_end(any_letter());
         end
         1: begin
            add_text(any_quote());
            repeat ($urandom_range(0, 5)) add_text(any_letter());
            add_end(CH_BSLASH);
         end
         2: begin
            add_text(CH_SLASH);
            add_text(CH_STAR);
            repeat ($urandom_range(0, 5)) add_text(any_letter());
            add_end(CH_STAR);
         end
         default: add_end(CH_SLASH);
      endcase
   endtask

   task automatic offer(input text_request_type item);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 6);
         repeat (gap) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      end
      req_tvalid <= 1'b1;
      req_tdata <= item.text;
      req_tlast <= item.last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      burst_left--;
   endtask

   initial begin
      int r;

      // bytes 00 and ff split by a separator
      add_text(CH_SQUOTE);
      add_text(8'h00);
      add_text(CH_SPACE);
      add_text(8'hff);
      add_text(CH_SQUOTE);
      // string of separators only
      add_text(CH_DQUOTE);
      add_text(CH_SEMI);
      add_text(CH_DQUOTE);
      // escaped closing quote
      add_text(CH_BTICK);
      add_text(CH_BSLASH);
      add_text(CH_BTICK);
      add_text(CH_BTICK);
      // line comment
      add_text(CH_SLASH);
      add_text(CH_SLASH);
      add_text(CH_LF);
      // block comment, opening star does not close it, star run does
      add_text(CH_SLASH);
      add_text(CH_STAR);
      add_text(CH_SLASH);
      add_text(CH_STAR);
      add_text(CH_STAR);
      add_text(CH_SLASH);
      // pending slash then a string
      add_text(CH_SLASH);
      add_text(CH_DQUOTE);
      add_text(8'h71);
      add_text(CH_DQUOTE);
      // end of input on an opening quote
      add_end(CH_SQUOTE);
      directed_len = script_text.size();

      while (script_text.size() < TEXT_TARGET) begin
         r = $urandom_range(0, 99);
         if (r < 45) add_string();
         else if (r < 60) add_code();
         else if (r < 70) add_line_comment();
         else if (r < 80) add_block_comment();
         else if (r < 90) add_noise();
         else add_cut_off();
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (script_text[i]) begin
         if (i == directed_len) hold_go <= 1'b1;
         if (script_text[i].last) eoi_count++;
         offer(script_text[i]);
      end
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("covered %0d script bytes with %0d end-of-input markers", script_text.size(),
               eoi_count);
      $display("checked %0d token bytes, %0d of them from truncated strings", token_count,
               truncated_count);
      if (fail_count == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

   // receiver: changing ready patterns, one long hold-off once random text starts
   initial begin
      ready_style_type style;
      int span;
      logic hold_done;
      hold_done = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (hold_go && !hold_done) begin
            hold_done = 1'b1;
            for (int n = 0; n < LONG_HOLD; n++) begin
               rsp_tready <= 1'b0;
               @(posedge clock);
            end
         end
         style = ready_style_type'($urandom_range(0, 3));
         span = $urandom_range(10, 60);
         for (int n = 0; n < span; n++) begin
            case (style)
               RX_STEADY: rsp_tready <= 1'b1;
               RX_COIN: rsp_tready <= 1'($urandom_range(0, 1));
               RX_SPARSE: rsp_tready <= ($urandom_range(0, 3) == 0);
               default: rsp_tready <= n[0];
            endcase
            @(posedge clock);
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $error("run did not finish within %0d cycles", CYCLE_LIMIT);
      $display("Simulation FAILED");
      $finish;
   end

endmodule

/* filelist.f */
rtl/core/jstok_pkg.sv
rtl/core/jstok_buffer.sv
rtl/core/jstok_scanner.sv
rtl/core/jstok_drain.sv
rtl/core/js_string_literal_tokenizer.sv
tb/sv/js_string_literal_tokenizer_checker.sv
tb/sv/js_string_literal_tokenizer_tb.sv
